FILE: hw/rtl/assert_macros.svh
// Assertion macros for the fixed-point ALU RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under active-low reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: imply");

// Next-cycle implication under active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next");

`endif

FILE: hw/rtl/fpa_pkg.sv
// Types and constants for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_REM  = 4'd4,
        CMD_NEG  = 4'd5,
        CMD_INC  = 4'd6,
        CMD_DEC  = 4'd7,
        CMD_FINT = 4'd8,
        CMD_TINT = 4'd9,
        CMD_CMP  = 4'd10
    } t_cmd;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [63:0] result;
        logic               is_equal;
        logic               is_less;
        logic               is_greater;
        logic               divide_by_zero;
    } t_out;

    // Queue entry: the word plus its classification.
    typedef struct packed {
        t_in  word;
        logic is_div;     // div or rem with non-zero divisor
        logic is_equal;
        logic is_less;
        logic is_greater;
        logic dz;
    } t_qent;

endpackage

FILE: hw/rtl/fpa_front.sv
// Front end of the fixed-point ALU: accepts words, classifies them, queues them.
// Depends on fpa_pkg.
module fpa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  fpa_pkg::t_in  i_word,
    output logic          o_busy,
    output logic          o_q_valid,
    output fpa_pkg::t_qent o_q_head,
    input  logic          i_pop
);

    fpa_pkg::t_qent              r_mem [fpa_pkg::QDEPTH];
    logic [fpa_pkg::QPTR_W-1:0] r_wp, n_wp;
    logic [fpa_pkg::QPTR_W-1:0] r_rp, n_rp;
    logic [fpa_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    fpa_pkg::t_qent              cls;
    logic                        push;
    logic                        pop;
    logic                        divop;

    assign o_busy    = (r_cnt == fpa_pkg::QCNT_W'(fpa_pkg::QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_head  = r_mem[r_rp];
    assign push      = i_start && !o_busy;
    assign pop       = i_pop && o_q_valid;

    always_comb begin
        divop = (i_word.command == fpa_pkg::CMD_DIV) || (i_word.command == fpa_pkg::CMD_REM);
        cls.word       = i_word;
        cls.is_equal   = (i_word.operand_a == i_word.operand_b);
        cls.is_less    = (i_word.operand_a <  i_word.operand_b);
        cls.is_greater = (i_word.operand_a >  i_word.operand_b);
        cls.dz         = divop && (i_word.operand_b == '0);
        cls.is_div     = divop && (i_word.operand_b != '0);
    end

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + fpa_pkg::QCNT_W'(push) - fpa_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

endmodule

FILE: hw/rtl/fpa_back.sv
// Back end of the fixed-point ALU: three-stage datapath plus a radix-2 divider.
// Depends on fpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpa_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  fpa_pkg::t_qent i_q_head,
    output logic           o_pop,
    output logic           o_strobe,
    output fpa_pkg::t_out  o_res
);

    typedef enum logic [2:0] {
        ST_FLOW = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // stage 1
    logic               r_s1_v;
    logic               r_s1_mul;
    logic signed [63:0] r_s1_simple;
    logic [63:0]        r_s1_ll, r_s1_lh, r_s1_hl, r_s1_hh, r_s1_corr;
    logic [3:0]         r_s1_flags;
    // stage 2
    logic               r_s2_v;
    fpa_pkg::t_out      r_s2;
    // output
    logic               r_out_v;
    fpa_pkg::t_out      r_out;
    // divider
    logic [127:0]       r_dd;
    logic [63:0]        r_dv, r_rm, r_qt;
    logic [6:0]         r_dcnt;
    logic               r_dneg, r_rneg, r_isrem;
    logic [3:0]         r_dflags;

    logic signed [63:0] a, b, simple;
    logic [63:0]        ma, mb;
    logic [127:0]       prod;
    logic [64:0]        rt;
    logic               ge;
    logic               pipe_empty;
    logic               take_div;

    assign a = i_q_head.word.operand_a;
    assign b = i_q_head.word.operand_b;
    assign ma = a[63] ? 64'(-a) : a;
    assign mb = b[63] ? 64'(-b) : b;
    assign pipe_empty = !r_s1_v && !r_s2_v;
    assign take_div = (r_state == ST_FLOW) && i_q_valid && i_q_head.is_div && pipe_empty;
    assign o_pop = (r_state == ST_FLOW) && i_q_valid && (!i_q_head.is_div || pipe_empty);

    always_comb begin
        unique case (fpa_pkg::t_cmd'(i_q_head.word.command))
            fpa_pkg::CMD_ADD:  simple = a + b;
            fpa_pkg::CMD_SUB:  simple = a - b;
            fpa_pkg::CMD_NEG:  simple = -a;
            fpa_pkg::CMD_INC:  simple = a + (64'sd1 <<< FRAC_BITS);
            fpa_pkg::CMD_DEC:  simple = a - (64'sd1 <<< FRAC_BITS);
            fpa_pkg::CMD_FINT: simple = a <<< FRAC_BITS;
            fpa_pkg::CMD_TINT: simple = a >>> FRAC_BITS;
            default:           simple = '0;
        endcase
    end

    always_comb begin
        prod = {r_s1_hh, r_s1_ll} + (128'(r_s1_lh) << 32) + (128'(r_s1_hl) << 32)
             - {r_s1_corr, 64'd0};
    end

    // one quotient bit a cycle
    always_comb begin
        rt = {r_rm, r_dd[127]};
        ge = (rt >= {1'b0, r_dv});
        if (ge) begin
            rt = rt - {1'b0, r_dv};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FLOW: if (take_div) n_state = ST_DIV;
            ST_DIV:  if (r_dcnt == 7'd127) n_state = ST_DONE;
            ST_DONE: n_state = ST_FLOW;
            default: n_state = ST_FLOW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FLOW;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_v  <= o_pop && !i_q_head.is_div;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v || (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mul    <= (i_q_head.word.command == fpa_pkg::CMD_MUL);
        r_s1_simple <= simple;
        r_s1_ll     <= 64'(a[31:0])  * 64'(b[31:0]);
        r_s1_lh     <= 64'(a[31:0])  * 64'(b[63:32]);
        r_s1_hl     <= 64'(a[63:32]) * 64'(b[31:0]);
        r_s1_hh     <= 64'(a[63:32]) * 64'(b[63:32]);
        r_s1_corr   <= (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
        r_s1_flags  <= {i_q_head.is_equal, i_q_head.is_less, i_q_head.is_greater, i_q_head.dz};

        r_s2.result         <= r_s1_mul ? prod[FRAC_BITS +: 64] : r_s1_simple;
        r_s2.is_equal       <= r_s1_flags[3];
        r_s2.is_less        <= r_s1_flags[2];
        r_s2.is_greater     <= r_s1_flags[1];
        r_s2.divide_by_zero <= r_s1_flags[0];

        if (r_state == ST_DONE) begin
            r_out.result         <= r_isrem ? (r_rneg ? -r_rm : r_rm)
                                            : (r_dneg ? -r_qt : r_qt);
            r_out.is_equal       <= r_dflags[3];
            r_out.is_less        <= r_dflags[2];
            r_out.is_greater     <= r_dflags[1];
            r_out.divide_by_zero <= r_dflags[0];
        end else begin
            r_out <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_div) begin
            r_isrem  <= (i_q_head.word.command == fpa_pkg::CMD_REM);
            r_dd     <= (i_q_head.word.command == fpa_pkg::CMD_REM) ? 128'(ma)
                                                                   : (128'(ma) << FRAC_BITS);
            r_dv     <= mb;
            r_rm     <= '0;
            r_qt     <= '0;
            r_dcnt   <= '0;
            r_dneg   <= a[63] ^ b[63];
            r_rneg   <= a[63];
            r_dflags <= {i_q_head.is_equal, i_q_head.is_less, i_q_head.is_greater, 1'b0};
        end else if (r_state == ST_DIV) begin
            r_dd   <= {r_dd[126:0], 1'b0};
            r_rm   <= rt[63:0];
            r_qt   <= {r_qt[62:0], ge};
            r_dcnt <= r_dcnt + 7'd1;
        end
    end

    assign o_strobe = r_out_v;
    assign o_res    = r_out;

    `ASSERT_IMPLY(a_no_pop_in_div, i_clk, i_rst_n, r_state != ST_FLOW, !o_pop)
    `ASSERT_IMPLY(a_div_drained, i_clk, i_rst_n, r_state == ST_DONE, !r_s1_v && !r_s2_v)
    `ASSERT_NEXT(a_done_once, i_clk, i_rst_n, r_state == ST_DONE, r_state == ST_FLOW && r_out_v)

endmodule

FILE: hw/rtl/fixed_point_alu.sv
// Top level of the 64-bit signed fixed-point ALU.
// Depends on fpa_pkg, fpa_front and fpa_back.
//
// Usage:
//   Command channel: a word (command, operand_a, operand_b) is taken at a
//   rising edge where start is high and busy is low. busy is high only when
//   the four-entry queue between front and back is full.
//   Result channel: o_strobe is high for one cycle with o_res holding the
//   result word; the receiver cannot hold results off, and results leave in
//   command order.
//   Datapath: add, sub, mul, neg, inc, dec, from_int, to_int, compare and
//   unknown codes pass queue, partial products, product sum and select, and
//   the output register; one word per cycle while no divide holds the queue.
//   div and rem with a non-zero divisor go through a radix-2 divider, one
//   quotient bit a cycle over a 128-bit dividend: it waits for the datapath
//   to drain, then runs 128 steps and a finish state; the next word leaves
//   the queue only after the finish state.
//   A zero divisor bypasses the divider: result 0 and divide_by_zero set.
//   Compare flags hold for every command.
//   Reset (synchronous, active low) empties the queue, clears the pipeline
//   valids and returns the divider sequencer to idle; no result is lost
//   by stalling since the output side never stalls.
module fixed_point_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  fpa_pkg::t_in  i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output fpa_pkg::t_out o_res
);

    logic           q_valid;
    logic           q_pop;
    fpa_pkg::t_qent q_head;

    fpa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_word    (i_cmd),
        .o_busy    (busy),
        .o_q_valid (q_valid),
        .o_q_head  (q_head),
        .i_pop     (q_pop)
    );

    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_strobe  (o_strobe),
        .o_res     (o_res)
    );

endmodule

FILE: tb/sv/fixed_point_alu_test.sv
// Self-checking testbench for the 64-bit signed fixed-point ALU.
// Depends on fpa_pkg and fixed_point_alu; predicts each result word and checks it.
module fixed_point_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_UNIT = 64'd1 << FRAC;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    fpa_pkg::t_in  i_cmd;
    logic          busy;
    logic          o_strobe;
    fpa_pkg::t_out o_res;

    // Expected result words, oldest first
    fpa_pkg::t_out expected_words[$];
    int   fail_count;
    int   word_count;
    int   div_count;

    fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_cmd),
        .busy(busy), .o_strobe(o_strobe), .o_res(o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous limit for the whole run, which includes many divide words
    initial begin
        #100ms;
        $display("fixed_point_alu test failed");
        $finish;
    end

    // Magnitude of a two's complement value, as an unsigned 64-bit number
    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Predict the result word for one command word
    function automatic fpa_pkg::t_out alu_predict(fpa_pkg::t_in w);
        fpa_pkg::t_out r;
        logic [3:0] op;
        logic signed [63:0] a, b;
        logic signed [127:0] prod;
        logic [127:0] num;
        logic [127:0] quot;
        logic [63:0] rm;
        op = w.command;
        a = w.operand_a;
        b = w.operand_b;
        r = '0;
        case (op)
            fpa_pkg::CMD_ADD: r.result = a + b;
            fpa_pkg::CMD_SUB: r.result = a - b;
            fpa_pkg::CMD_MUL: begin
                prod = 128'(a) * 128'(b);
                r.result = 64'(prod >>> FRAC);
            end
            fpa_pkg::CMD_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    // unsigned long division of magnitudes, then sign
                    num = {64'd0, magnitude(a)} << FRAC;
                    quot = num / {64'd0, magnitude(b)};
                    r.result = (a[63] ^ b[63]) ? (64'd0 - quot[63:0]) : quot[63:0];
                end
            end
            fpa_pkg::CMD_REM: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    rm = magnitude(a) % magnitude(b);
                    r.result = a[63] ? (64'd0 - rm) : rm;
                end
            end
            fpa_pkg::CMD_NEG:  r.result = 64'd0 - a;
            fpa_pkg::CMD_INC:  r.result = a + ONE_UNIT;
            fpa_pkg::CMD_DEC:  r.result = a - ONE_UNIT;
            fpa_pkg::CMD_FINT: r.result = a << FRAC;
            fpa_pkg::CMD_TINT: r.result = a >>> FRAC;
            default:           r.result = '0;
        endcase
        // flags compare the operands whatever the command
        r.is_equal   = (a == b);
        r.is_less    = (a < b);
        r.is_greater = (a > b);
        return r;
    endfunction

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        fpa_pkg::t_out exp_w;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", o_res);
                fail_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_res.result !== exp_w.result) begin
                    $error("result: expected %h, got %h", exp_w.result, o_res.result);
                    fail_count++;
                end
                if (o_res.is_equal !== exp_w.is_equal) begin
                    $error("is_equal: expected %b, got %b", exp_w.is_equal, o_res.is_equal);
                    fail_count++;
                end
                if (o_res.is_less !== exp_w.is_less) begin
                    $error("is_less: expected %b, got %b", exp_w.is_less, o_res.is_less);
                    fail_count++;
                end
                if (o_res.is_greater !== exp_w.is_greater) begin
                    $error("is_greater: expected %b, got %b", exp_w.is_greater,
                        o_res.is_greater);
                    fail_count++;
                end
                if (o_res.divide_by_zero !== exp_w.divide_by_zero) begin
                    $error("divide_by_zero: expected %b, got %b", exp_w.divide_by_zero,
                        o_res.divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    // Send one word: optional idle gap, then hold start until taken.
    // start stays high afterwards so the next word can follow with no gap.
    task automatic send_word(logic [3:0] op, logic [63:0] a, logic [63:0] b, int gap);
        fpa_pkg::t_in w;
        w.command = op;
        w.operand_a = a;
        w.operand_b = b;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        // taken at this edge; expectation logged before the strobe can come
        expected_words.push_back(alu_predict(w));
        word_count++;
        if ((op == fpa_pkg::CMD_DIV || op == fpa_pkg::CMD_REM) && b != 0) div_count++;
    endtask

    // Stop sending and wait until every expected word has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Operand with a bias towards edge values and small numbers
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return 64'(signed'($urandom_range(0, 6)) - 3);
            3: return 64'(signed'($urandom_range(0, 16'hFFFF))) << $urandom_range(0, 40);
            4: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
            default: return rand64();
        endcase
    endfunction

    // Gap drawn per word; some stretches run without gaps
    function automatic int draw_gap(bit busy_phase);
        return busy_phase ? 0 : $urandom_range(0, 15);
    endfunction

    // Extremes of the operands through every command
    task automatic test_directed();
        logic [3:0] op;
        for (int c = fpa_pkg::CMD_ADD; c <= fpa_pkg::CMD_CMP; c++) begin
            op = 4'(c);
            send_word(op, MAX_VAL, 64'd1, 0);
            send_word(op, MIN_VAL, 64'hFFFF_FFFF_FFFF_FFFF, $urandom_range(0, 3));
        end
        // zero divisor, rounding of to_int, equal operands, unknown codes
        send_word(fpa_pkg::CMD_DIV, 64'd12345, 64'd0, 0);
        send_word(fpa_pkg::CMD_REM, MIN_VAL, 64'd0, 0);
        send_word(fpa_pkg::CMD_TINT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 0);
        send_word(fpa_pkg::CMD_CMP, 64'd7, 64'd7, 0);
        send_word(4'd11, MAX_VAL, MIN_VAL, 0);
        send_word(4'd15, rand64(), rand64(), 0);
    endtask

    // Random words over all sixteen codes, mostly the defined ones
    task automatic test_random(int n);
        logic [3:0] op;
        logic [63:0] b;
        bit burst;
        burst = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            // keep dividers rare so the run stays short
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                               : 4'($urandom_range(0, 10));
            if ((op == fpa_pkg::CMD_DIV || op == fpa_pkg::CMD_REM) &&
                $urandom_range(0, 3) != 0)
                op = fpa_pkg::CMD_ADD;
            b = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_operand();
            if ($urandom_range(0, 15) == 0) b = '0;
            send_word(op, rand_operand(), ($urandom_range(0, 7) == 0) ? rand64() : b,
                draw_gap(burst));
            // sender holds off once until the pipeline is empty
            if (i == n / 2) drain_results();
        end
    endtask

    // Back-to-back divides to fill the queue and exercise busy
    task automatic test_divide_backpressure();
        for (int i = 0; i < 12; i++)
            send_word($urandom_range(0, 1) ? fpa_pkg::CMD_DIV : fpa_pkg::CMD_REM,
                rand_operand(), rand_operand() | 64'd1, 0);
    endtask

    initial begin
        fail_count = 0;
        word_count = 0;
        div_count = 0;
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_divide_backpressure();
        test_random(1700);

        drain_results();
        repeat (200) @(posedge i_clk);

        $display("Checked %0d words across all command codes, %0d through the divider.",
            word_count, div_count);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("fixed_point_alu test passed");
        end else begin
            $display("fixed_point_alu test failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_alu.sv
tb/sv/fixed_point_alu_test.sv
